// File: src/wgf_pkg.sv
// shared types, constants and the max tree for the window gap-fill filter
`timescale 1ns / 1ps
`default_nettype none
package wgf_pkg;

   localparam int HALF_WINDOW = 5;
   localparam int SAMPLE_BITS = 16;
   localparam int DEPTH       = 2 * HALF_WINDOW;
   localparam int NCHAN       = 4;
   localparam int CHAN_BITS   = 16;
   localparam int DATA_BITS   = NCHAN * CHAN_BITS;
   localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SEEN_BITS   = $clog2(DEPTH + 1);
   localparam int CNT_BITS    = $clog2(HALF_WINDOW + 1);
   localparam int TREE_LEVELS = $clog2(HALF_WINDOW);
   localparam int TREE_LEAVES = 1 << TREE_LEVELS;

   typedef logic [SAMPLE_BITS-1:0]    sample_type;
   typedef sample_type [NCHAN-1:0]    row_type;
   typedef sample_type [HALF_WINDOW-1:0] half_type;

   typedef struct packed {
      logic valid;
      logic filt;
      logic last;
   } stage_ctl_type;

   // pairwise max tree, padded with zeros up to a power of two
   function automatic sample_type max_of_half(input half_type v);
      sample_type t [TREE_LEAVES];
      for (int i = 0; i < TREE_LEAVES; i++) begin
         t[i] = '0;
      end
      for (int i = 0; i < HALF_WINDOW; i++) begin
         t[i] = v[i];
      end
      for (int lvl = 0; lvl < TREE_LEVELS; lvl++) begin
         for (int i = 0; i < (TREE_LEAVES >> (lvl + 1)); i++) begin
            t[i] = (t[2*i] > t[2*i+1]) ? t[2*i] : t[2*i+1];
         end
      end
      return t[0];
   endfunction

endpackage
`default_nettype wire

// File: src/wgf_lane.sv
// one channel lane: window maxima, registered, then min or pass-through
`timescale 1ns / 1ps
`default_nettype none
module wgf_lane (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire wgf_pkg::half_type before_win,
   input  wire wgf_pkg::half_type after_win,
   input  wire wgf_pkg::sample_type pass_val,
   input  wire logic              filt,
   output wgf_pkg::sample_type    result
);
   import wgf_pkg::*;

   sample_type max_before_ff, max_before_in;
   sample_type max_after_ff, max_after_in;
   sample_type pass_ff;

   assign max_before_in = max_of_half(before_win);
   assign max_after_in  = max_of_half(after_win);

   always_ff @(posedge clock) begin
      if (load) begin
         max_before_ff <= max_before_in;
         max_after_ff  <= max_after_in;
         pass_ff       <= pass_val;
      end
   end

   always_comb begin
      if (filt) begin
         result = (max_after_ff > max_before_ff) ? max_before_ff : max_after_ff;
      end else begin
         result = pass_ff;
      end
   end

endmodule
`default_nettype wire

// File: src/wgf_merge.sv
// output register that gathers the lane results into one transaction
`timescale 1ns / 1ps
`default_nettype none
module wgf_merge (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire wgf_pkg::stage_ctl_type stage,
   input  wire wgf_pkg::row_type       lane_res,
   output logic                        ready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [wgf_pkg::DATA_BITS-1:0] rsp_tdata, // out0, out1, out2, out3
   output logic                        rsp_tuser,  // was_filtered
   output logic                        rsp_tlast   // end_of_table
);
   import wgf_pkg::*;

   logic                 valid_ff, valid_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic                 user_ff;
   logic                 last_ff;
   logic                 load;

   assign ready = !valid_ff || rsp_tready;
   assign load  = stage.valid && ready;

   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         data_in[c*CHAN_BITS +: CHAN_BITS] = CHAN_BITS'(lane_res[c]);
      end
      valid_in = ready ? stage.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= stage.filt;
         last_ff <= stage.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// File: src/window_gap_fill_filter.sv
// top level of the window gap-fill filter: row window, lanes and flush sequencer
`timescale 1ns / 1ps
`default_nettype none
// usage
// - req channel: one row per transaction, four 16-bit channel counts in tdata
//   (chan0 in the lowest bits), tlast marks the last row of a table
// - rsp channel: one output row per transaction, four channels in tdata,
//   tuser high when the row got the min of the two window maxima, tlast high on
//   the final row of the table
// - a row leaves HALF_WINDOW rows after it came in; the first HALF_WINDOW rows of a
//   table produce nothing until then
// - the row released by an accepted transaction passes the lane maxima register and
//   then the output register before it shows on rsp
// - throughput: one row per cycle unless rsp stalls or a flush runs; the window
//   shifts once per non-last row, and the lane max trees read the window registers
// - on the last row the window is frozen and the held rows are flushed oldest first,
//   one per cycle while rsp does not stall, ending with the last row itself;
//   req_tready stays low while that runs
// - tables of 2*HALF_WINDOW rows or fewer pass through unfiltered
// - reset (synchronous) empties the pipeline and starts a new table; window
//   contents are never read before they are written, so they are not cleared
// - a stalled rsp holds the output register; one row waits in the lane register
//   so req keeps flowing until both are full
module window_gap_fill_filter (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [wgf_pkg::DATA_BITS-1:0] req_tdata, // chan0, chan1, chan2, chan3
   input  wire logic                         req_tlast,  // final_row
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [wgf_pkg::DATA_BITS-1:0]     rsp_tdata,  // out0, out1, out2, out3
   output logic                              rsp_tuser,  // was_filtered
   output logic                              rsp_tlast   // end_of_table
);
   import wgf_pkg::*;

   // window_ff[d] holds the row taken d+1 transactions ago
   row_type window_ff [DEPTH];
   row_type window_in [DEPTH];
   row_type cur_ff, cur_in;
   row_type cur_row;
   row_type pass_row;
   row_type lane_res;

   logic [SEEN_BITS-1:0] seen_ff, seen_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  start_cnt;
   logic [IDX_BITS-1:0]  flush_idx;
   logic                 flush_ff, flush_in;

   logic s1_valid_ff, s1_valid_in;
   logic s1_filt_ff, s1_filt_in;
   logic s1_last_ff, s1_last_in;

   logic          merge_ready;
   logic          s1_free;
   logic          accept;
   logic          gen_valid;
   stage_ctl_type stage;

   half_type before_col [NCHAN];
   half_type after_col  [NCHAN];

   // stage 1 can take a new row when empty or when it moves on this cycle
   assign s1_free    = !s1_valid_ff || merge_ready;
   assign req_tready = !flush_ff && s1_free;
   assign accept     = req_tvalid && req_tready;

   // a row is released on a transaction once half a window is held, and every
   // free cycle of a flush releases one held row
   assign gen_valid = (accept && (seen_ff >= SEEN_BITS'(HALF_WINDOW))) ||
                      (flush_ff && s1_free);

   assign start_cnt = (seen_ff < SEEN_BITS'(HALF_WINDOW - 1)) ?
                      CNT_BITS'(seen_ff) : CNT_BITS'(HALF_WINDOW - 1);
   assign flush_idx = IDX_BITS'(cnt_ff - CNT_BITS'(1));

   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         cur_row[c] = SAMPLE_BITS'(req_tdata[c*CHAN_BITS +: CHAN_BITS]);
      end
   end

   // pass-through row: the delayed row, a held row during flush, or the last row
   always_comb begin
      if (!flush_ff) begin
         pass_row = window_ff[HALF_WINDOW-1];
      end else if (cnt_ff != '0) begin
         pass_row = window_ff[flush_idx];
      end else begin
         pass_row = cur_ff;
      end
   end

   // window columns for each lane
   for (genvar c = 0; c < NCHAN; c++) begin : g_col
      for (genvar k = 0; k < HALF_WINDOW; k++) begin : g_tap
         assign before_col[c][k] = window_ff[HALF_WINDOW + k][c];
         assign after_col[c][k]  = window_ff[k][c];
      end
   end

   always_comb begin
      window_in   = window_ff;
      cur_in      = cur_ff;
      seen_in     = seen_ff;
      cnt_in      = cnt_ff;
      flush_in    = flush_ff;
      s1_valid_in = s1_valid_ff;
      s1_filt_in  = s1_filt_ff;
      s1_last_in  = s1_last_ff;

      if (s1_free) begin
         s1_valid_in = gen_valid;
         s1_filt_in  = accept && (seen_ff >= SEEN_BITS'(DEPTH));
         s1_last_in  = flush_ff && (cnt_ff == '0);
      end

      if (accept) begin
         if (req_tlast) begin
            // freeze the window and start the flush
            flush_in = 1'b1;
            cnt_in   = start_cnt;
            cur_in   = cur_row;
         end else begin
            window_in[0] = cur_row;
            for (int d = 1; d < DEPTH; d++) begin
               window_in[d] = window_ff[d-1];
            end
            if (seen_ff < SEEN_BITS'(DEPTH)) begin
               seen_in = seen_ff + SEEN_BITS'(1);
            end
         end
      end else if (flush_ff && s1_free) begin
         if (cnt_ff == '0) begin
            flush_in = 1'b0;
            seen_in  = '0;
         end else begin
            cnt_in = cnt_ff - CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         cnt_ff      <= '0;
         flush_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         s1_filt_ff  <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         cnt_ff      <= cnt_in;
         flush_ff    <= flush_in;
         s1_valid_ff <= s1_valid_in;
         s1_filt_ff  <= s1_filt_in;
         s1_last_ff  <= s1_last_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      cur_ff    <= cur_in;
   end

   // one lane per channel
   for (genvar c = 0; c < NCHAN; c++) begin : g_lane
      wgf_lane u_lane (
         .clock      (clock),
         .load       (gen_valid),
         .before_win (before_col[c]),
         .after_win  (after_col[c]),
         .pass_val   (pass_row[c]),
         .filt       (s1_filt_ff),
         .result     (lane_res[c])
      );
   end

   assign stage.valid = s1_valid_ff;
   assign stage.filt  = s1_filt_ff;
   assign stage.last  = s1_last_ff;

   wgf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .lane_res   (lane_res),
      .ready      (merge_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// File: verif/window_gap_fill_filter_tb.sv
// self-checking testbench for the window gap-fill filter: directed and random tables
`timescale 1ns / 1ps
`default_nettype none
module window_gap_fill_filter_tb;

   import wgf_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned RANDOM_ROWS   = 294;
   localparam int unsigned PRINT_LIMIT   = 40;
   localparam int unsigned SETTLE_CYCLES = 8;

   // kinds of random row
   localparam int unsigned ROW_RANDOM  = 0;
   localparam int unsigned ROW_LEVEL   = 1;
   localparam int unsigned ROW_EXTREME = 2;

   typedef logic [CHAN_BITS-1:0] count_type;
   // packed so that chan0 sits in the lowest bits, as on tdata
   typedef count_type [NCHAN-1:0] counts_type;

   typedef struct {
      counts_type counts;
      logic       filtered;
      logic       table_end;
   } out_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata = '0;  // chan0, chan1, chan2, chan3
   logic                 req_tlast = 1'b0; // final_row
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;        // out0, out1, out2, out3
   logic                 rsp_tuser;        // was_filtered
   logic                 rsp_tlast;        // end_of_table

   // predictor state: raw rows of the current table, newest at index 0
   counts_type  recent_rows [DEPTH];
   int unsigned rows_taken = 0;
   out_row_type pending_rows [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_hold_off = 0;
   bit          steady_flow = 1'b0;

   window_gap_fill_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic count_type to_sample(count_type raw);
      count_type sample_mask;
      sample_mask = count_type'((64'd1 << SAMPLE_BITS) - 64'd1);
      return raw & sample_mask;
   endfunction

   function automatic void push_out_row(counts_type counts, logic filtered, logic table_end);
      out_row_type r;
      r.counts    = counts;
      r.filtered  = filtered;
      r.table_end = table_end;
      pending_rows = {pending_rows, r};
   endfunction

   // works out the output rows released by one accepted row
   function automatic void apply_gap_fill(counts_type raw, bit last_row);
      counts_type cur;
      counts_type delayed;
      count_type  max_before;
      count_type  max_after;
      bit         filtered;
      int         flush_from;
      for (int c = 0; c < NCHAN; c++) begin
         cur[c] = to_sample(raw[c]);
      end
      // the row half a window back leaves now
      if (rows_taken >= HALF_WINDOW) begin
         filtered = (rows_taken >= DEPTH);
         for (int c = 0; c < NCHAN; c++) begin
            if (filtered) begin
               max_before = '0;
               max_after  = '0;
               for (int d = HALF_WINDOW; d < DEPTH; d++) begin
                  if (recent_rows[d][c] > max_before) max_before = recent_rows[d][c];
               end
               for (int d = 0; d < HALF_WINDOW; d++) begin
                  if (recent_rows[d][c] > max_after) max_after = recent_rows[d][c];
               end
               delayed[c] = (max_after > max_before) ? max_before : max_after;
            end else begin
               delayed[c] = recent_rows[HALF_WINDOW-1][c];
            end
         end
         push_out_row(delayed, filtered, 1'b0);
      end
      if (last_row) begin
         // flush what is still held, oldest first, then the last row itself
         flush_from = (rows_taken < HALF_WINDOW - 1) ? int'(rows_taken) : HALF_WINDOW - 1;
         for (int d = flush_from - 1; d >= 0; d--) begin
            push_out_row(recent_rows[d], 1'b0, 1'b0);
         end
         push_out_row(cur, 1'b0, 1'b1);
         rows_taken = 0;
         for (int d = 0; d < DEPTH; d++) begin
            recent_rows[d] = '0;
         end
      end else begin
         for (int d = DEPTH - 1; d > 0; d--) begin
            recent_rows[d] = recent_rows[d-1];
         end
         recent_rows[0] = cur;
         if (rows_taken < DEPTH) rows_taken++;
      end
   endfunction

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
      end
      mismatch_count++;
   endtask

   // one row per transaction; called right after a rising edge
   task automatic send_row(counts_type counts, bit last_row);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= counts;
      req_tlast  <= last_row;
      do @(posedge clock); while (!req_tready);
      apply_gap_fill(counts, last_row);
      gap = (steady_flow || $urandom_range(0, 99) < 50) ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every released row has come out
   task automatic drain_pause();
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (rsp_hold_off > 0) begin
         rsp_tready   <= 1'b0;
         rsp_hold_off <= rsp_hold_off - 1;
      end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
         rsp_tready   <= 1'b0;
         rsp_hold_off <= idle_length() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare every rsp transaction with the oldest expected row
   always @(posedge clock) begin
      out_row_type want;
      counts_type  got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_rows.size() == 0) begin
            report_mismatch("unexpected row, tdata", 0, rsp_tdata);
         end else begin
            want = pending_rows.pop_front();
            for (int c = 0; c < NCHAN; c++) begin
               if (got[c] !== want.counts[c]) begin
                  report_mismatch($sformatf("out%0d", c), want.counts[c], got[c]);
               end
            end
            if (rsp_tuser !== want.filtered) begin
               report_mismatch("was_filtered", want.filtered, rsp_tuser);
            end
            if (rsp_tlast !== want.table_end) begin
               report_mismatch("end_of_table", want.table_end, rsp_tlast);
            end
         end
      end
   end

   // one-row tables at both extremes
   task automatic test_single_row();
      send_row('1, 1'b1);
      send_row('0, 1'b1);
   endtask

   // tables too short to filter, including exactly a full window
   task automatic test_short_tables();
      counts_type r;
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < NCHAN; c++) r[c] = count_type'(i * NCHAN + c + 1);
         send_row(r, i == 2);
      end
      for (int i = 0; i < DEPTH; i++) begin
         r = (i % 2 == 0) ? '1 : '0;
         send_row(r, i == DEPTH - 1);
      end
   endtask

   // a steady level with a short dropout and a spike on one channel
   task automatic test_dropout_fill();
      counts_type r;
      for (int i = 0; i < DEPTH + 1; i++) begin
         for (int c = 0; c < NCHAN; c++) r[c] = count_type'(16'h8000 + c);
         if (i >= 4 && i <= 6) r = '0;
         if (i == 2) r[3] = '1;
         send_row(r, i == DEPTH);
      end
   endtask

   function automatic counts_type make_row(int unsigned style, counts_type level);
      counts_type  r;
      int unsigned k;
      for (int c = 0; c < NCHAN; c++) begin
         case (style)
            ROW_RANDOM: begin
               r[c] = count_type'($urandom);
            end
            ROW_LEVEL: begin
               // level with jitter and dropouts to be filled
               r[c] = ($urandom_range(0, 99) < 15) ? '0 :
                      count_type'(level[c] + $urandom_range(0, 15));
            end
            default: begin
               k = $urandom_range(0, 3);
               r[c] = (k == 0) ? '0 : (k == 1) ? '1 : count_type'($urandom_range(0, 7));
            end
         endcase
      end
      return r;
   endfunction

   // random tables of random length, mostly short, a few long
   task automatic test_random_tables();
      int unsigned rows_sent;
      int unsigned table_len;
      int unsigned style;
      int unsigned r;
      counts_type  level;
      bit          paused;
      rows_sent = 0;
      paused    = 1'b0;
      while (rows_sent < RANDOM_ROWS) begin
         r = $urandom_range(0, 99);
         if (r < 55)      table_len = $urandom_range(1, DEPTH + 3);
         else if (r < 90) table_len = $urandom_range(DEPTH + 1, 30);
         else             table_len = $urandom_range(31, 60);
         if (table_len > RANDOM_ROWS - rows_sent) table_len = RANDOM_ROWS - rows_sent;
         style       = $urandom_range(ROW_RANDOM, ROW_EXTREME);
         level       = counts_type'({$urandom, $urandom});
         steady_flow = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < table_len; i++) begin
            send_row(make_row(style, level), i == table_len - 1);
            rows_sent++;
            if (!paused && rows_sent >= RANDOM_ROWS / 2 && i != table_len - 1) begin
               drain_pause();
               paused = 1'b1;
            end
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_row();
      test_short_tables();
      test_dropout_fill();
      test_random_tables();
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// File: window_gap_fill_filter.f
src/wgf_pkg.sv
src/wgf_lane.sv
src/wgf_merge.sv
src/window_gap_fill_filter.sv
verif/window_gap_fill_filter_tb.sv
